### rtl/core/hci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_pkg
// Shared types, constants and palette tables for the heat-map colormap block.
// ----------------------------------------------------------------------------
package hci_pkg;

    localparam int CHANNEL_BITS          = 8;
    localparam int LEVEL_WIDTH           = 18;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int STOP_INDEX_BITS       = 4;

    typedef logic [CHANNEL_BITS-1:0]    channel_t;
    typedef logic [STOP_INDEX_BITS-1:0] stop_index_t;

    typedef struct packed {
        channel_t red;
        channel_t green;
        channel_t blue;
    } color_t;

    typedef struct packed {
        color_t lower;
        color_t upper;
    } stop_pair_t;

    typedef enum logic {
        PAL_BLUE_WHITE_RED = 1'b0,
        PAL_VIRIDIS        = 1'b1
    } palette_t;

    localparam stop_index_t BWR_LAST     = 4'd2;
    localparam stop_index_t VIRIDIS_LAST = 4'd8;

    function automatic color_t stop_color(palette_t pal, stop_index_t idx);
        color_t c;
        c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
        if (pal == PAL_BLUE_WHITE_RED)
        begin
            case (idx)
                4'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
                4'd1:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
                4'd2:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
                default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    c = '{red: 8'd69,  green: 8'd4,   blue: 8'd87};
                4'd1:    c = '{red: 8'd71,  green: 8'd42,  blue: 8'd122};
                4'd2:    c = '{red: 8'd60,  green: 8'd80,  blue: 8'd139};
                4'd3:    c = '{red: 8'd46,  green: 8'd111, blue: 8'd142};
                4'd4:    c = '{red: 8'd34,  green: 8'd140, blue: 8'd141};
                4'd5:    c = '{red: 8'd35,  green: 8'd169, blue: 8'd131};
                4'd6:    c = '{red: 8'd78,  green: 8'd195, blue: 8'd107};
                4'd7:    c = '{red: 8'd149, green: 8'd216, blue: 8'd64};
                4'd8:    c = '{red: 8'd248, green: 8'd230, blue: 8'd33};
                default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
            endcase
        end
        return c;
    endfunction

endpackage

### rtl/core/hci_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_locate
// Clamps the level, scales it by the segment count and picks the two stops
// and the blend fraction.
// ----------------------------------------------------------------------------
module hci_locate #(
    parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic signed [hci_pkg::LEVEL_WIDTH-1:0] level,
    input  hci_pkg::palette_t                      palette,
    output hci_pkg::stop_pair_t                    stops,
    output logic [FRACTION_BITS-1:0]               frac
);
    import hci_pkg::*;

    localparam int MAG_BITS = LEVEL_WIDTH - 1;
    localparam int CMP_BITS = (FRACTION_BITS + 1 > MAG_BITS) ? FRACTION_BITS + 1 : MAG_BITS;
    localparam int SCL_BITS = (FRACTION_BITS + 3 > MAG_BITS + 3) ? FRACTION_BITS + 3
                                                                 : MAG_BITS + 3;

    logic                 not_positive;
    logic                 at_or_above_one;
    logic [CMP_BITS-1:0]  level_cmp;
    logic [SCL_BITS-1:0]  level_wide;
    logic [SCL_BITS-1:0]  scaled;
    logic [SCL_BITS-1:0]  scaled_int;
    stop_index_t          last_idx;
    stop_index_t          lower_idx;
    stop_index_t          upper_idx;

    always_comb
    begin
        not_positive    = level[LEVEL_WIDTH-1] || (level == '0);
        level_cmp       = CMP_BITS'(level[MAG_BITS-1:0]);
        at_or_above_one = level_cmp >= (CMP_BITS'(1) << FRACTION_BITS);
        level_wide      = SCL_BITS'(level[MAG_BITS-1:0]);
        last_idx        = (palette == PAL_VIRIDIS) ? VIRIDIS_LAST : BWR_LAST;
        scaled          = (palette == PAL_VIRIDIS) ? (level_wide << 3) : (level_wide << 1);
        scaled_int      = scaled >> FRACTION_BITS;

        if (not_positive)
        begin
            lower_idx = '0;
            upper_idx = '0;
            frac      = '0;
        end
        else if (at_or_above_one)
        begin
            lower_idx = last_idx;
            upper_idx = last_idx;
            frac      = '0;
        end
        else
        begin
            lower_idx = {1'b0, scaled_int[2:0]};
            upper_idx = lower_idx + 4'd1;
            frac      = scaled[FRACTION_BITS-1:0];
        end

        stops.lower = stop_color(palette, lower_idx);
        stops.upper = stop_color(palette, upper_idx);
    end

endmodule

### rtl/core/hci_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_blend
// Linear blend of one color channel between two stops, rounded to nearest.
// ----------------------------------------------------------------------------
module hci_blend #(
    parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
    input  hci_pkg::channel_t        lower,
    input  hci_pkg::channel_t        upper,
    input  logic [FRACTION_BITS-1:0] frac,
    output hci_pkg::channel_t        result
);
    import hci_pkg::*;

    localparam int PRD_BITS = FRACTION_BITS + CHANNEL_BITS + 2;

    logic signed [CHANNEL_BITS:0] diff;
    logic signed [PRD_BITS-1:0]   product;
    logic signed [PRD_BITS-1:0]   total;

    always_comb
    begin
        diff    = $signed({1'b0, upper}) - $signed({1'b0, lower});
        product = PRD_BITS'(diff) * PRD_BITS'($signed({1'b0, frac}));
        total   = product
                + $signed(PRD_BITS'({1'b0, lower}) << FRACTION_BITS)
                + $signed(PRD_BITS'(1) << (FRACTION_BITS - 1));
        result  = total[FRACTION_BITS +: CHANNEL_BITS];
    end

endmodule

### rtl/core/heatmap_colormap_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heatmap_colormap_interpolator
// Maps a signed fixed-point level to an RGB pseudo-color by piecewise linear
// interpolation between the stops of a selectable palette.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Busy stays low, so one request can be taken on every clock cycle.
// The request is held in an input register, and the color is computed by
// combinational logic into the result register in the next cycle.
// The result appears on red, green and blue with done high for one cycle,
// starting at the edge after the accepting edge, as the valid register
// feeds the done register.
// Throughput is one request per cycle, as only combinational logic lies
// between the input and result registers.
// The receiver cannot stall: done marks each result for a single cycle.
// The user must write the palette register through cfg_we and cfg_wdata
// while no request is in flight; the block itself does not enforce this.
// Reset clears the palette selection to the blue-white-red palette and
// drops any request in flight.
// ----------------------------------------------------------------------------
module heatmap_colormap_interpolator #(
    parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_wdata,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [hci_pkg::LEVEL_WIDTH-1:0] level,
    output logic                                   done,
    output hci_pkg::channel_t                      red,
    output hci_pkg::channel_t                      green,
    output hci_pkg::channel_t                      blue
);
    import hci_pkg::*;

    palette_t                       palette_reg;
    logic                           valid_reg;
    logic signed [LEVEL_WIDTH-1:0]  level_reg;
    palette_t                       req_palette_reg;
    logic                           done_reg;
    color_t                         color_reg;
    color_t                         color_next;
    stop_pair_t                     stops;
    logic [FRACTION_BITS-1:0]       frac;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= PAL_BLUE_WHITE_RED;
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                palette_reg <= palette_t'(cfg_wdata);
            end
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            level_reg       <= level;
            req_palette_reg <= palette_reg;
        end
        if (valid_reg)
        begin
            color_reg <= color_next;
        end
    end

    hci_locate #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_locate (
        .level   (level_reg),
        .palette (req_palette_reg),
        .stops   (stops),
        .frac    (frac)
    );

    hci_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend_red (
        .lower  (stops.lower.red),
        .upper  (stops.upper.red),
        .frac   (frac),
        .result (color_next.red)
    );

    hci_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend_green (
        .lower  (stops.lower.green),
        .upper  (stops.upper.green),
        .frac   (frac),
        .result (color_next.green)
    );

    hci_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend_blue (
        .lower  (stops.lower.blue),
        .upper  (stops.upper.blue),
        .frac   (frac),
        .result (color_next.blue)
    );

    assign done  = done_reg;
    assign red   = color_reg.red;
    assign green = color_reg.green;
    assign blue  = color_reg.blue;

    // Every accepted request yields a result on done, via the valid and done registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |=> !done)
        else $error("result strobe without a request");

    // A level at or below zero must give the first stop exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (level_reg[LEVEL_WIDTH-1] || level_reg == '0))
        |=> (color_reg == stop_color($past(req_palette_reg), '0)))
        else $error("non-positive level did not map to the first stop");

    // A zero fraction must return the lower stop unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frac == '0) |=> (color_reg == $past(stops.lower)))
        else $error("zero fraction did not return the lower stop");

endmodule
